// File: rtl/number_to_ascii_formatter_assert.svh
// assertion macros for the number to ascii formatter
`ifndef NUMBER_TO_ASCII_FORMATTER_ASSERT_SVH
`define NUMBER_TO_ASCII_FORMATTER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define NAF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define NAF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/naf_pkg.sv
// shared constants and helpers for the number to ascii formatter
package naf_pkg;

  localparam int unsigned MAX_CHARS = 20;
  localparam int unsigned BCD_W     = 4 * MAX_CHARS;
  localparam int unsigned VAL_W     = 64;

  // format kinds carried on tuser
  localparam logic [2:0] KIND_SDEC  = 3'd0;
  localparam logic [2:0] KIND_BINNZ = 3'd1;
  localparam logic [2:0] KIND_BIN16 = 3'd2;
  localparam logic [2:0] KIND_BIN8  = 3'd3;
  localparam logic [2:0] KIND_HEX8  = 3'd4;
  localparam logic [2:0] KIND_DEC4  = 3'd5;

  localparam logic [6:0] ASCII_ZERO  = 7'h30;
  localparam logic [6:0] ASCII_ONE   = 7'h31;
  localparam logic [6:0] ASCII_MINUS = 7'h2d;
  localparam logic [6:0] ASCII_A     = 7'h41;

  function automatic logic [6:0] hex_char(input logic [3:0] d);
    logic [6:0] c;
    if (d < 4'd10) begin
      c = ASCII_ZERO + {3'b000, d};
    end else begin
      c = ASCII_A + {3'b000, d} - 7'd10;
    end
    return c;
  endfunction

endpackage

// File: rtl/number_to_ascii_formatter.sv
// Number to ASCII formatter.
// Input channel: in_tuser carries the format kind (0 signed decimal, 1 binary
// without leading zeros, 2 binary16, 3 binary8, 4 hex8, 5 decimal4), in_tdata
// the 64-bit two's complement value. Output channel: one ASCII character per
// request on out_tdata, most significant first, out_tlast on the final one.
// Decimal formats go through a bit-serial double dabble, one value bit per
// cycle, over all 64 value bits for signed decimal and 16 for decimal4. Signed
// decimal then drops up to 19 leading zero digits, one per cycle, sends an
// optional minus sign and the digits. Binary without leading zeros drops one
// leading zero bit per cycle.
// One item is in work at a time; the next is taken as soon as the final
// character sits in the output register, even while it waits there.
// Kinds 6 and 7 are accepted and produce no characters, as does a zero value
// in binary without leading zeros.
// A receiver stall holds the output register and pauses the character shift.
// Reset empties the output register and returns to idle.
`include "number_to_ascii_formatter_assert.svh"

module number_to_ascii_formatter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // value[63:0]
  input  logic [2:0]  in_tuser,   // kind[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // ch[6:0], zero pad [7]
  output logic        out_tlast
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CONV  = 5'b00010,
    ST_STRIP = 5'b00100,
    ST_SIGN  = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  localparam int unsigned BW = naf_pkg::BCD_W;
  localparam int unsigned VW = naf_pkg::VAL_W;

  state_t          state_r, state_nxt;
  logic [BW-1:0]   sr_r, sr_nxt;
  logic [VW-1:0]   bin_r, bin_nxt;
  logic [5:0]      conv_cnt_r, conv_cnt_nxt;
  logic [4:0]      cnt_r, cnt_nxt;
  logic            dig_r, dig_nxt;
  logic            neg_r, neg_nxt;
  logic            dec4_r, dec4_nxt;
  logic            out_tvalid_r, out_tvalid_nxt;
  logic [6:0]      out_ch_r, out_ch_nxt;
  logic            out_last_r, out_last_nxt;

  logic [BW-1:0]   corr;
  logic [BW-1:0]   dabble;
  logic [VW-1:0]   mag;
  logic            out_free;
  logic            top_zero;
  logic [6:0]      cur_ch;

  // add-3 correction on every bcd digit, then shift in the next value bit
  always_comb begin
    for (int i = 0; i < naf_pkg::MAX_CHARS; i++) begin
      if (sr_r[4*i +: 4] >= 4'd5) begin
        corr[4*i +: 4] = sr_r[4*i +: 4] + 4'd3;
      end else begin
        corr[4*i +: 4] = sr_r[4*i +: 4];
      end
    end
    dabble = {corr[BW-2:0], bin_r[VW-1]};
  end

  assign mag      = in_tdata[VW-1] ? (64'd0 - in_tdata) : in_tdata;
  assign out_free = !out_tvalid_r || out_tready;
  assign top_zero = dig_r ? (sr_r[BW-1 -: 4] == 4'd0) : !sr_r[BW-1];
  assign cur_ch   = dig_r ? naf_pkg::hex_char(sr_r[BW-1 -: 4])
                          : (sr_r[BW-1] ? naf_pkg::ASCII_ONE : naf_pkg::ASCII_ZERO);
  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    sr_nxt         = sr_r;
    bin_nxt        = bin_r;
    conv_cnt_nxt   = conv_cnt_r;
    cnt_nxt        = cnt_r;
    dig_nxt        = dig_r;
    neg_nxt        = neg_r;
    dec4_nxt       = dec4_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_ch_nxt     = out_ch_r;
    out_last_nxt   = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          neg_nxt  = 1'b0;
          dec4_nxt = 1'b0;
          dig_nxt  = 1'b0;
          case (in_tuser)
            naf_pkg::KIND_SDEC: begin
              neg_nxt      = in_tdata[VW-1];
              bin_nxt      = mag;
              sr_nxt       = '0;
              conv_cnt_nxt = 6'd63;
              state_nxt    = ST_CONV;
            end
            naf_pkg::KIND_BINNZ: begin
              sr_nxt    = {in_tdata[15:0], {(BW-16){1'b0}}};
              cnt_nxt   = 5'd16;
              state_nxt = ST_STRIP;
            end
            naf_pkg::KIND_BIN16: begin
              sr_nxt    = {in_tdata[15:0], {(BW-16){1'b0}}};
              cnt_nxt   = 5'd16;
              state_nxt = ST_EMIT;
            end
            naf_pkg::KIND_BIN8: begin
              sr_nxt    = {in_tdata[7:0], {(BW-8){1'b0}}};
              cnt_nxt   = 5'd8;
              state_nxt = ST_EMIT;
            end
            naf_pkg::KIND_HEX8: begin
              sr_nxt    = {in_tdata[7:0], {(BW-8){1'b0}}};
              cnt_nxt   = 5'd2;
              dig_nxt   = 1'b1;
              state_nxt = ST_EMIT;
            end
            naf_pkg::KIND_DEC4: begin
              bin_nxt      = {in_tdata[15:0], {(VW-16){1'b0}}};
              sr_nxt       = '0;
              conv_cnt_nxt = 6'd15;
              dec4_nxt     = 1'b1;
              state_nxt    = ST_CONV;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_CONV: begin
        sr_nxt       = dabble;
        bin_nxt      = {bin_r[VW-2:0], 1'b0};
        conv_cnt_nxt = conv_cnt_r - 6'd1;
        if (conv_cnt_r == 6'd0) begin
          dig_nxt = 1'b1;
          if (dec4_r) begin
            // keep the low four digits: value mod 10000
            sr_nxt    = {dabble[15:0], {(BW-16){1'b0}}};
            cnt_nxt   = 5'd4;
            state_nxt = ST_EMIT;
          end else begin
            cnt_nxt   = 5'(naf_pkg::MAX_CHARS);
            state_nxt = ST_STRIP;
          end
        end
      end
      ST_STRIP: begin
        if (cnt_r == 5'd0) begin
          state_nxt = ST_IDLE;
        end else if (top_zero && !(dig_r && cnt_r == 5'd1)) begin
          sr_nxt  = dig_r ? (sr_r << 4) : (sr_r << 1);
          cnt_nxt = cnt_r - 5'd1;
        end else begin
          state_nxt = neg_r ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_ch_nxt     = naf_pkg::ASCII_MINUS;
          out_last_nxt   = 1'b0;
          state_nxt      = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_ch_nxt     = cur_ch;
          out_last_nxt   = (cnt_r == 5'd1);
          sr_nxt         = dig_r ? (sr_r << 4) : (sr_r << 1);
          cnt_nxt        = cnt_r - 5'd1;
          if (cnt_r == 5'd1) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
      cnt_r        <= '0;
      conv_cnt_r   <= '0;
      neg_r        <= 1'b0;
      dec4_r       <= 1'b0;
      dig_r        <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      cnt_r        <= cnt_nxt;
      conv_cnt_r   <= conv_cnt_nxt;
      neg_r        <= neg_nxt;
      dec4_r       <= dec4_nxt;
      dig_r        <= dig_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sr_r       <= sr_nxt;
    bin_r      <= bin_nxt;
    out_ch_r   <= out_ch_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {1'b0, out_ch_r};
  assign out_tlast  = out_last_r;

  `NAF_ASSERT_NOW(a_state_onehot, 1'b1, $onehot(state_r), "state not one-hot")
  `NAF_ASSERT_NOW(a_emit_cnt, state_r == ST_EMIT, cnt_r != 5'd0, "emit with no chars left")
  `NAF_ASSERT_NOW(a_sign_neg, state_r == ST_SIGN, neg_r && dig_r, "sign without negative")
  `NAF_ASSERT_NOW(a_dec4_len, (state_r == ST_CONV) && dec4_r, conv_cnt_r <= 6'd15,
    "decimal4 conversion too long")
  `NAF_ASSERT_NEXT(a_last_idle, (state_r == ST_EMIT) && out_free && (cnt_r == 5'd1),
    out_tlast && out_tvalid && (state_r == ST_IDLE), "final char not marked")

endmodule
